// ----- rtl/mpr_pkg.sv -----
package mpr_pkg;

  localparam int NUM_COEF           = 7;
  localparam int DEF_MAX_TERMS      = 7;
  localparam int DEF_MAX_PASSES     = 64;
  localparam int DEF_FRAC_BITS      = 16;
  localparam int CFG_INDEX_W        = 4;
  localparam int DIV_NUM_W          = 64;
  localparam int DIV_DEN_W          = 40;

  localparam logic [CFG_INDEX_W-1:0] REG_TERM_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_LAST  = 4'd7;

  typedef enum logic [1:0] {
    ST_CONVERGED   = 2'd0,
    ST_NO_REAL     = 2'd1,
    ST_ITER_LIMIT  = 2'd2,
    ST_ZERO_DIV    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PASS,
    S_HCHK,
    S_HMUL,
    S_HADD,
    S_D0,
    S_D0W,
    S_D1,
    S_D1W,
    S_DA,
    S_DAW,
    S_MAH,
    S_B,
    S_MBB,
    S_MAC,
    S_Q,
    S_SQW,
    S_DX,
    S_DXW
  } state_t;

  typedef struct packed {
    logic signed [31:0] guess_a;
    logic signed [31:0] guess_b;
    logic signed [31:0] guess_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] root;
    logic [1:0]         status;
    logic [6:0]         passes;
  } out_t;

endpackage

// ----- rtl/muller_polynomial_root_finder.sv -----
// Muller root finder on a fixed-point polynomial.
// Configuration: write term_count (index 0) and coef_0..coef_6 (indices 1..7,
// highest power first) over cfg_valid/cfg_ready; cfg_ready is always high and
// writes to other indices are dropped. Write only while busy is low.
// Input: a transaction is taken when start is high and busy is low; it carries
// three Q16.16 starting guesses. busy stays high until the run ends.
// Output: done pulses for one cycle with root, status and passes on result.
// The receiver cannot stall; result holds its value until the next done.
// Each pass runs three Horner evaluations on the shared multiplier, four
// divisions on the bit-serial divider (one quotient bit per cycle), a square
// root on the square-root unit, plus bookkeeping states. A run takes up to
// MAX_PASSES passes; one transaction is in flight at a time.
// Reset clears term_count to 1, all coefficients and the guess state to zero
// and returns the sequencer to idle.
module muller_polynomial_root_finder #(
  parameter int MAX_TERMS  = mpr_pkg::DEF_MAX_TERMS,
  parameter int MAX_PASSES = mpr_pkg::DEF_MAX_PASSES,
  parameter int FRAC_BITS  = mpr_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mpr_pkg::in_t                       guesses,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                        cfg_data,
  output logic                               done,
  output mpr_pkg::out_t                      result
);

  localparam int NW = mpr_pkg::DIV_NUM_W;
  localparam int DW = mpr_pkg::DIV_DEN_W;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh0000_0000_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(t);
  endfunction

  // configuration
  logic [2:0]         term_count;
  logic signed [31:0] coef [mpr_pkg::NUM_COEF];
  logic [2:0]         n_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= 3'd1;
      for (int i = 0; i < mpr_pkg::NUM_COEF; i++) coef[i] <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mpr_pkg::REG_TERM_COUNT) begin
        term_count <= cfg_data[2:0];
      end else if (cfg_index <= mpr_pkg::REG_COEF_LAST) begin
        coef[3'(cfg_index - 1'b1)] <= $signed(cfg_data);
      end
    end
  end

  always_comb begin
    if (term_count == 3'd0) n_eff = 3'd1;
    else if (term_count > 3'(MAX_TERMS)) n_eff = 3'(MAX_TERMS);
    else n_eff = term_count;
  end

  // datapath registers
  mpr_pkg::state_t    state, state_next;
  logic signed [31:0] g0, g1, g2;
  logic signed [31:0] h0, h1, f0, f1, f2;
  logic signed [31:0] p, x, d0, d1, a, b;
  logic signed [63:0] prod, acc, work_accumulator;
  logic signed [DW-1:0] den;
  logic [2:0]         term_idx;
  logic [1:0]         pt;
  logic [6:0]         pass_counter;

  // combinational helpers
  logic signed [32:0] h0_raw, h1_raw;
  logic signed [31:0] h0_c, h1_c;
  logic signed [32:0] hsum;
  logic signed [63:0] q_c;
  logic [63:0]        work_accumulator_next_u;
  logic signed [33:0] dd;
  logic signed [32:0] g3_raw;
  logic signed [31:0] g3_c;
  logic signed [33:0] chg;
  logic [32:0]        chg_abs, g3_abs;
  logic [42:0]        chg_k;
  logic               conv;
  logic signed [31:0] mul_x, mul_y;
  logic signed [63:0] mul_p;

  // shared units
  logic                 div_go, div_done;
  logic                 sq_go, sq_done;
  logic signed [NW-1:0] div_num;
  logic signed [DW-1:0] div_den;
  logic signed [31:0]   div_q;
  logic [31:0]          sq_root;

  mpr_divider #(.NUM_W(NW), .DEN_W(DW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_q)
  );

  mpr_isqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .val  (work_accumulator_next_u),
    .done (sq_done),
    .root (sq_root)
  );

  assign h0_raw = 33'(g1) - 33'(g0);
  assign h1_raw = 33'(g2) - 33'(g1);
  assign h0_c   = sat32(64'(h0_raw));
  assign h1_c   = sat32(64'(h1_raw));
  assign hsum   = 33'(h0) + 33'(h1);
  assign q_c    = acc - prod;
  assign work_accumulator_next_u = q_c;
  assign dd     = 34'({sq_root, 1'b0});
  assign g3_raw = 33'(g2) + 33'(div_q);
  assign g3_c   = sat32(64'(g3_raw));
  assign chg    = 34'(g3_c) - 34'(g2);
  assign chg_abs = chg[33] ? 33'(-chg) : 33'(chg);
  assign g3_abs  = g3_c[31] ? 33'(-34'(g3_c)) : 33'(g3_c);
  assign chg_k   = {chg_abs, 10'b0} - {6'b0, chg_abs, 4'b0} - {7'b0, chg_abs, 3'b0};
  assign conv    = chg_k <= 43'(g3_abs);

  // one multiplier, operands picked by the sequencer
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      mpr_pkg::S_HMUL: begin
        mul_x = p;
        mul_y = x;
      end
      mpr_pkg::S_MAH: begin
        mul_x = a;
        mul_y = h1;
      end
      mpr_pkg::S_MBB: begin
        mul_x = b;
        mul_y = b;
      end
      mpr_pkg::S_MAC: begin
        mul_x = a;
        mul_y = f2;
      end
      default: ;
    endcase
  end

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  always_comb begin
    div_num = '0;
    div_den = '0;
    unique case (state)
      mpr_pkg::S_D0: begin
        div_num = NW'(64'(33'(f1) - 33'(f0)) <<< FRAC_BITS);
        div_den = DW'(h0);
      end
      mpr_pkg::S_D1: begin
        div_num = NW'(64'(33'(f2) - 33'(f1)) <<< FRAC_BITS);
        div_den = DW'(h1);
      end
      mpr_pkg::S_DA: begin
        div_num = NW'(64'(33'(d1) - 33'(d0)) <<< FRAC_BITS);
        div_den = DW'(hsum);
      end
      mpr_pkg::S_DX: begin
        div_num = NW'(-(64'(f2) <<< 1) <<< FRAC_BITS);
        div_den = den;
      end
      default: ;
    endcase
  end

  assign div_go = (state == mpr_pkg::S_D0) || (state == mpr_pkg::S_D1) ||
                  (state == mpr_pkg::S_DA) || (state == mpr_pkg::S_DX);
  assign sq_go  = (state == mpr_pkg::S_Q) && (q_c > 64'sd0);
  assign busy   = state != mpr_pkg::S_IDLE;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= mpr_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mpr_pkg::S_IDLE: if (start) state_next = mpr_pkg::S_PASS;
      mpr_pkg::S_PASS: begin
        if (h0_c == '0 || h1_c == '0 || (33'(h0_c) + 33'(h1_c)) == '0)
          state_next = mpr_pkg::S_IDLE;
        else
          state_next = mpr_pkg::S_HCHK;
      end
      mpr_pkg::S_HCHK: begin
        if (term_idx < n_eff) state_next = mpr_pkg::S_HMUL;
        else if (pt == 2'd2)  state_next = mpr_pkg::S_D0;
      end
      mpr_pkg::S_HMUL: state_next = mpr_pkg::S_HADD;
      mpr_pkg::S_HADD: state_next = mpr_pkg::S_HCHK;
      mpr_pkg::S_D0:   state_next = mpr_pkg::S_D0W;
      mpr_pkg::S_D0W:  if (div_done) state_next = mpr_pkg::S_D1;
      mpr_pkg::S_D1:   state_next = mpr_pkg::S_D1W;
      mpr_pkg::S_D1W:  if (div_done) state_next = mpr_pkg::S_DA;
      mpr_pkg::S_DA:   state_next = mpr_pkg::S_DAW;
      mpr_pkg::S_DAW:  if (div_done) state_next = mpr_pkg::S_MAH;
      mpr_pkg::S_MAH:  state_next = mpr_pkg::S_B;
      mpr_pkg::S_B:    state_next = mpr_pkg::S_MBB;
      mpr_pkg::S_MBB:  state_next = mpr_pkg::S_MAC;
      mpr_pkg::S_MAC:  state_next = mpr_pkg::S_Q;
      mpr_pkg::S_Q:    state_next = (q_c > 64'sd0) ? mpr_pkg::S_SQW : mpr_pkg::S_IDLE;
      mpr_pkg::S_SQW:  if (sq_done) state_next = mpr_pkg::S_DX;
      mpr_pkg::S_DX:   state_next = mpr_pkg::S_DXW;
      mpr_pkg::S_DXW: begin
        if (div_done) begin
          if (conv || pass_counter == 7'(MAX_PASSES)) state_next = mpr_pkg::S_IDLE;
          else state_next = mpr_pkg::S_PASS;
        end
      end
      default: state_next = mpr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done             <= 1'b0;
      g0               <= '0;
      g1               <= '0;
      g2               <= '0;
      pass_counter     <= '0;
      work_accumulator <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        mpr_pkg::S_IDLE: begin
          if (start) begin
            g0           <= guesses.guess_a;
            g1           <= guesses.guess_b;
            g2           <= guesses.guess_c;
            pass_counter <= '0;
          end
        end
        mpr_pkg::S_PASS: begin
          pass_counter <= pass_counter + 1'b1;
          h0           <= h0_c;
          h1           <= h1_c;
          pt           <= 2'd0;
          x            <= g0;
          p            <= coef[0];
          term_idx     <= 3'd1;
          if (h0_c == '0 || h1_c == '0 || (33'(h0_c) + 33'(h1_c)) == '0) begin
            result.root   <= g2;
            result.status <= mpr_pkg::ST_ZERO_DIV;
            result.passes <= pass_counter + 1'b1;
            done          <= 1'b1;
          end
        end
        mpr_pkg::S_HCHK: begin
          if (term_idx >= n_eff) begin
            unique case (pt)
              2'd0:    f0 <= p;
              2'd1:    f1 <= p;
              default: f2 <= p;
            endcase
            // advance to the next sample point
            pt       <= pt + 1'b1;
            x        <= (pt == 2'd0) ? g1 : g2;
            p        <= coef[0];
            term_idx <= 3'd1;
          end
        end
        mpr_pkg::S_HMUL: prod <= mul_p;
        mpr_pkg::S_HADD: begin
          p        <= sat32(64'(qmul_round(prod)) + 64'(coef[term_idx]));
          term_idx <= term_idx + 1'b1;
        end
        mpr_pkg::S_D0W: if (div_done) d0 <= div_q;
        mpr_pkg::S_D1W: if (div_done) d1 <= div_q;
        mpr_pkg::S_DAW: if (div_done) a <= div_q;
        mpr_pkg::S_MAH: prod <= mul_p;
        mpr_pkg::S_B:   b <= sat32(64'(qmul_round(prod)) + 64'(d1));
        mpr_pkg::S_MBB: prod <= mul_p;
        mpr_pkg::S_MAC: begin
          acc  <= prod >>> 2;
          prod <= mul_p;
        end
        mpr_pkg::S_Q: begin
          work_accumulator <= q_c;
          if (q_c <= 64'sd0) begin
            result.root   <= g2;
            result.status <= mpr_pkg::ST_NO_REAL;
            result.passes <= pass_counter;
            done          <= 1'b1;
          end
        end
        mpr_pkg::S_SQW: begin
          if (sq_done) begin
            den <= b[31] ? DW'(34'(b) - dd) : DW'(34'(b) + dd);
          end
        end
        mpr_pkg::S_DXW: begin
          if (div_done) begin
            g0 <= g1;
            g1 <= g2;
            g2 <= g3_c;
            if (conv || pass_counter == 7'(MAX_PASSES)) begin
              result.root   <= g3_c;
              result.status <= conv ? mpr_pkg::ST_CONVERGED : mpr_pkg::ST_ITER_LIMIT;
              result.passes <= pass_counter;
              done          <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a run in progress");

  a_passes_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.passes != '0 && result.passes <= 7'(MAX_PASSES)))
    else $error("pass count out of range");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("sequencer still busy after result");

  a_sqrt_positive: assert property (@(posedge clk) disable iff (rst)
    sq_go |=> work_accumulator > 64'sd0)
    else $error("square root started on non-positive discriminant");

endmodule

// ----- rtl/mpr_divider.sv -----
module mpr_divider #(
  parameter int NUM_W = mpr_pkg::DIV_NUM_W,
  parameter int DEN_W = mpr_pkg::DIV_DEN_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DEN_W-1:0] den,
  output logic                    done,
  output logic signed [31:0]      quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             act;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem, nmag[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        act  <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
        neg  <= num[NUM_W-1] ^ den[DEN_W-1];
        nmag <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        dmag <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
        rem  <= '0;
      end else if (act) begin
        rem  <= ge ? DEN_W'(rem_sh - {1'b0, dmag}) : rem_sh[DEN_W-1:0];
        nmag <= {nmag[NUM_W-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          act  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // clamp quotient magnitude to the signed 32-bit range
  always_comb begin
    if (!neg) begin
      quot = (nmag > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(nmag[31:0]);
    end else begin
      quot = (nmag > NUM_W'(33'h0_8000_0000)) ? 32'sh8000_0000 : $signed(-nmag[31:0]);
    end
  end

endmodule

// ----- rtl/mpr_isqrt.sv -----
module mpr_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic        act;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      act  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        act  <= 1'b1;
        cnt  <= '1;
        v    <= val;
        r    <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (act) begin
        if (v >= trial) begin
          v <= v - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          act  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- bench/tb_muller_polynomial_root_finder.sv -----
module tb_muller_polynomial_root_finder;

  localparam int FB = mpr_pkg::DEF_FRAC_BITS;
  localparam int NPASS = mpr_pkg::DEF_MAX_PASSES;
  localparam int NTERMS = mpr_pkg::DEF_MAX_TERMS;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  mpr_pkg::in_t guesses = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mpr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  mpr_pkg::out_t result;

  muller_polynomial_root_finder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .guesses(guesses),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Root finder predictor with its own copy of the coefficient registers.
  class root_scoreboard;
    logic [2:0] terms;
    longint coefs[mpr_pkg::NUM_COEF];
    mpr_pkg::out_t pending[$];
    int errors;
    int checked;
    int status_seen[4];

    function new();
      terms = 3'd1;
      foreach (coefs[i]) coefs[i] = 0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(logic [mpr_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
      if (idx == mpr_pkg::REG_TERM_COUNT) begin
        terms = data[2:0];
      end else if (idx <= mpr_pkg::REG_COEF_LAST) begin
        coefs[idx - 1] = longint'(signed'(data));
      end
    endfunction

    function longint clamp(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    function longint fx_mul(longint x, longint y);
      return clamp((x * y + (64'sd1 <<< (FB - 1))) >>> FB);
    endfunction

    function longint fx_div(longint n, longint d);
      return clamp((n * (64'sd1 <<< FB)) / d);
    endfunction

    function longint int_sqrt(longint v);
      longint unsigned r, bit_w, x;
      x = v;
      r = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > x) bit_w >>= 2;
      while (bit_w != 0) begin
        if (x >= r + bit_w) begin
          x -= r + bit_w;
          r = (r >> 1) + bit_w;
        end else begin
          r >>= 1;
        end
        bit_w >>= 2;
      end
      return longint'(r);
    endfunction

    function longint horner(longint x);
      int n;
      longint p;
      n = terms;
      if (n < 1) n = 1;
      if (n > NTERMS) n = NTERMS;
      p = coefs[0];
      for (int i = 1; i < n; i++) p = clamp(fx_mul(p, x) + coefs[i]);
      return p;
    endfunction

    function void note_start(mpr_pkg::in_t g);
      longint x0, x1, x2, x3, h0, h1, f0, f1, f2, d0, d1, a, b, c, q, dd, den, dx;
      mpr_pkg::out_t r;
      x0 = longint'(g.guess_a);
      x1 = longint'(g.guess_b);
      x2 = longint'(g.guess_c);
      r.root = x2[31:0];
      r.status = mpr_pkg::ST_ITER_LIMIT;
      r.passes = '0;
      for (int k = 1; k <= NPASS; k++) begin
        r.passes = k[6:0];
        h0 = clamp(x1 - x0);
        h1 = clamp(x2 - x1);
        if (h0 == 0 || h1 == 0 || h0 + h1 == 0) begin
          r.status = mpr_pkg::ST_ZERO_DIV;
          r.root = x2[31:0];
          break;
        end
        f0 = horner(x0);
        f1 = horner(x1);
        f2 = horner(x2);
        d0 = fx_div(f1 - f0, h0);
        d1 = fx_div(f2 - f1, h1);
        a = fx_div(d1 - d0, h0 + h1);
        b = clamp(fx_mul(a, h1) + d1);
        c = f2;
        q = (b * b) / 4 - a * c;
        if (q <= 0) begin
          r.status = mpr_pkg::ST_NO_REAL;
          r.root = x2[31:0];
          break;
        end
        dd = 2 * int_sqrt(q);
        den = (b >= 0) ? b + dd : b - dd;
        x3 = clamp(x2 + fx_div(-2 * c, den));
        x0 = x1;
        x1 = x2;
        x2 = x3;
        r.root = x3[31:0];
        dx = x3 - x1;
        if (dx < 0) dx = -dx;
        if (dx * 1000 <= (x3 < 0 ? -x3 : x3)) begin
          r.status = mpr_pkg::ST_CONVERGED;
          break;
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(mpr_pkg::out_t got);
      mpr_pkg::out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result root=%h status=%0d passes=%0d",
                 $time, got.root, got.status, got.passes);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      status_seen[want.status]++;
      if (got.root !== want.root) begin
        $display("%0t: root expected %h actual %h", $time, want.root, got.root);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.passes !== want.passes) begin
        $display("%0t: passes expected %0d actual %0d", $time, want.passes, got.passes);
        errors++;
      end
    endfunction
  endclass

  root_scoreboard sb = new();
  int n_items = 0;

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  task automatic idle_gap();
    repeat ($urandom_range(0, 4)) @(negedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[mpr_pkg::CFG_INDEX_W-1:0];
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx[mpr_pkg::CFG_INDEX_W-1:0], data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_guesses(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    mpr_pkg::in_t g;
    idle_gap();
    g.guess_a = a;
    g.guess_b = b;
    g.guess_c = c;
    @(negedge clk);
    start <= 1'b1;
    guesses <= g;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_start(g);
    n_items++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Small coefficients keep most runs well away from saturation.
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sd0;
      default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_guess();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
      default: return $signed($urandom_range(0, 16 << 16)) - (8 << 16);
    endcase
  endfunction

  task automatic load_poly(int n, longint c0, longint c1, longint c2);
    write_reg(mpr_pkg::REG_TERM_COUNT, n);
    write_reg(1, c0[31:0]);
    write_reg(2, c1[31:0]);
    write_reg(3, c2[31:0]);
    for (int i = 4; i <= mpr_pkg::NUM_COEF; i++) write_reg(i, 32'h0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // x^2 - 2 : converging runs, bad guesses, extremes
    load_poly(3, 1 << 16, 0, -(2 << 16));
    run_guesses(0, 1 << 16, 2 << 16);
    run_guesses(-(3 << 16), -(2 << 16), -(1 << 16));
    run_guesses(1 << 16, 1 << 16, 2 << 16);
    run_guesses(0, 1 << 16, 1 << 16);
    run_guesses(0, 1 << 16, 0);
    run_guesses(32'h8000_0000, 0, 32'h7fff_ffff);
    run_guesses(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    run_guesses(32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa);
    drain();
    // x^2 + 1 : no real roots
    load_poly(3, 1 << 16, 0, 1 << 16);
    run_guesses(0, 1 << 16, 2 << 16);
    run_guesses(-(1 << 16), 1 << 15, 3 << 16);
    drain();
    // constant polynomial with term count 0, full term count, indices above range
    load_poly(0, 5 << 16, 0, 0);
    run_guesses(0, 1 << 16, 2 << 16);
    drain();
    write_reg(mpr_pkg::REG_TERM_COUNT, 7);
    for (int i = 1; i <= mpr_pkg::NUM_COEF; i++)
      write_reg(i, (i == 1 || i == 7) ? 32'h7fff_ffff : 0);
    run_guesses(1 << 16, 2 << 16, 3 << 16);
    drain();
    write_reg(mpr_pkg::REG_TERM_COUNT, 1);
    write_reg(8, 32'h1234_5678);
    write_reg(15, 32'hffff_ffff);
    run_guesses(0, 1 << 16, 2 << 16);
    drain();
    // x^3 - x : root near zero, b of zero
    load_poly(4, 1 << 16, 0, -(1 << 16));
    write_reg(4, 0);
    run_guesses(-(1 << 16), 0, 1 << 16);
    run_guesses(-(1 << 14), 1 << 13, 1 << 14);
    run_guesses(32'h8000_0000, 32'hc000_0000, 32'h7fff_ffff);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_reg(mpr_pkg::REG_TERM_COUNT,
                (phase == 0) ? 7 : (phase == 1) ? 2 : $urandom_range(0, 7));
      for (int i = 1; i <= mpr_pkg::NUM_COEF; i++) write_reg(i, rand_coef());
      repeat (25) run_guesses(rand_guess(), rand_guess(), rand_guess());
      drain();
    end

    $display("Ran %0d root searches, %0d results checked.", n_items, sb.checked);
    $display("Status mix: converged %0d, no real %0d, limit %0d, zero divisor %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #300000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
